// ===== rtl/core/fpba_pkg.sv =====
package fpba_pkg;

    // Fixed widths of the word fields.
    localparam int unsigned IDX_FIELD_W = 4;
    localparam int unsigned AMT_FIELD_W = 16;

    // Configuration port widths: two registers, data as wide as the widest.
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 5;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;

    // Fit policy codes. The unused code behaves as first fit.
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    // Register reset values.
    localparam logic [1:0] FIT_MODE_RST    = FIT_FIRST;
    localparam logic [4:0] BLOCK_COUNT_RST = 5'd16;

    // Input operation codes.
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // Input word.
    typedef struct packed {
        logic                   op;
        logic [IDX_FIELD_W-1:0] load_index;
        logic [AMT_FIELD_W-1:0] amount;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic                   granted;
        logic [IDX_FIELD_W-1:0] chosen_block;
        logic [AMT_FIELD_W-1:0] space_left;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // write one block size
        logic start;   // latch request amount, clear search state
        logic scan;    // read the next table entry
        logic finish;  // write back the chosen block, present the result
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic limit_zero;  // no block in use
        logic last;        // the entry being read is the last one in use
    } t_dp_status;

endpackage

// ===== rtl/core/fit_policy_block_allocator.sv =====
// Load word: written to the table on acceptance, no result; busy stays low.
// Request word: busy after acceptance while the N table entries in use are read (N = blocks
// in use), the last entry read is compared (S_DRAIN) and the chosen block is written back
// (S_DONE). The result strobe is registered from S_DONE, and no new word is taken while busy;
// with no block in use the scan is skipped and the controller goes straight to S_DONE.
// The one-cycle result cannot be stalled. Synchronous active-low reset clears the controller,
// fit_mode to first fit, block_count to 16.
module fit_policy_block_allocator #(
    parameter int unsigned NUM_BLOCKS = 16,
    parameter int unsigned SIZE_BITS  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  fpba_pkg::t_in_word              i_in_word,
    output logic                            o_result_strobe,
    output fpba_pkg::t_out_word             o_out_word,
    input  logic                            i_cfg_we,
    input  logic [fpba_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fpba_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    fpba_pkg::t_dp_cmd    cmd;
    fpba_pkg::t_dp_status status;

    // Sequencer.
    fpba_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_op     (i_in_word.op),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    // Table, search and result datapath.
    fpba_dp #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_word       (i_in_word),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_result_strobe (o_result_strobe),
        .o_out_word      (o_out_word)
    );

endmodule

// ===== rtl/core/fpba_ctrl.sv =====
module fpba_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                i_op,
    input  fpba_pkg::t_dp_status i_status,
    output fpba_pkg::t_dp_cmd   o_cmd,
    output logic                busy
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // Next state and datapath commands.
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_op == fpba_pkg::OP_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state = i_status.limit_zero ? S_DONE : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // The last entry read is compared in this cycle.
                n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/fpba_dp.sv =====
module fpba_dp #(
    parameter int unsigned NUM_BLOCKS = 16,
    parameter int unsigned SIZE_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fpba_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fpba_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  fpba_pkg::t_in_word                  i_in_word,
    input  fpba_pkg::t_dp_cmd                   i_cmd,
    output fpba_pkg::t_dp_status                o_status,
    output logic                                o_result_strobe,
    output fpba_pkg::t_out_word                 o_out_word
);

    localparam int unsigned IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int unsigned CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int unsigned LIM_W = (CNT_W > 5) ? CNT_W : 5;

    // Configuration registers.
    logic [1:0]           r_fit_mode;
    logic [4:0]           r_block_count;

    // Free space table.
    logic [SIZE_BITS-1:0] mem [NUM_BLOCKS];
    logic [SIZE_BITS-1:0] r_rd_data;
    logic [IDX_W-1:0]     r_rd_idx;
    logic                 r_rd_vld;

    // Search state.
    logic [IDX_W-1:0]     r_addr;
    logic [SIZE_BITS-1:0] r_amt;
    logic                 r_found;
    logic [IDX_W-1:0]     r_pick;
    logic [SIZE_BITS-1:0] r_best;

    // Result register.
    logic                 r_out_vld;
    fpba_pkg::t_out_word  r_out;

    logic [LIM_W-1:0]     bc_ext;
    logic [LIM_W-1:0]     limit;
    logic [SIZE_BITS-1:0] amt_cut;
    logic [SIZE_BITS-1:0] remain;
    logic                 load_ok;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [SIZE_BITS-1:0] wr_data;
    logic                 fits;
    logic                 take;

    // Blocks in use, saturated at the table depth.
    assign bc_ext = LIM_W'(r_block_count);
    assign limit  = (bc_ext > LIM_W'(NUM_BLOCKS)) ? LIM_W'(NUM_BLOCKS) : bc_ext;

    assign o_status.limit_zero = (limit == '0);
    assign o_status.last       = ((LIM_W'(r_addr) + LIM_W'(1)) == limit);

    assign amt_cut = SIZE_BITS'(i_in_word.amount);
    assign remain  = r_best - r_amt;

    // Table write port: loads, and write-back of the chosen block.
    assign load_ok = (32'(i_in_word.load_index) < NUM_BLOCKS);
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_pick;
        wr_data = remain;
        if (i_cmd.load) begin
            wr_en   = load_ok;
            wr_addr = IDX_W'(i_in_word.load_index);
            wr_data = amt_cut;
        end else if (i_cmd.finish) begin
            wr_en = r_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[r_addr];
    end

    // Policy decision on the entry that just came out of the table.
    assign fits = (r_amt <= r_rd_data);
    always_comb begin
        take = 1'b0;
        if (r_rd_vld && fits) begin
            if (!r_found) begin
                take = 1'b1;
            end else begin
                case (r_fit_mode)
                    fpba_pkg::FIT_BEST:  take = (r_rd_data < r_best);
                    fpba_pkg::FIT_WORST: take = (r_rd_data > r_best);
                    default:             take = 1'b0;
                endcase
            end
        end
    end

    // Payload registers of the search.
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
        if (i_cmd.start) begin
            r_amt <= amt_cut;
        end
        if (take) begin
            r_pick <= r_rd_idx;
            r_best <= r_rd_data;
        end
        if (i_cmd.finish) begin
            r_out.granted      <= r_found;
            r_out.chosen_block <= r_found ? fpba_pkg::IDX_FIELD_W'(r_pick) : '0;
            r_out.space_left   <= r_found ? fpba_pkg::AMT_FIELD_W'(remain) : '0;
        end
    end

    // Control registers: configuration, scan address, flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode    <= fpba_pkg::FIT_MODE_RST;
            r_block_count <= fpba_pkg::BLOCK_COUNT_RST;
            r_addr        <= '0;
            r_rd_vld      <= 1'b0;
            r_found       <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    fpba_pkg::REG_FIT_MODE:    r_fit_mode    <= i_cfg_data[1:0];
                    fpba_pkg::REG_BLOCK_COUNT: r_block_count <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_rd_vld  <= i_cmd.scan;
            r_out_vld <= i_cmd.finish;
            if (i_cmd.start) begin
                r_addr  <= '0;
                r_found <= 1'b0;
            end else begin
                if (i_cmd.scan) begin
                    r_addr <= r_addr + IDX_W'(1);
                end
                if (take) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    assign o_result_strobe = r_out_vld;
    assign o_out_word      = r_out;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int unsigned    BLOCKS        = 16;
    localparam logic [1:0]     FIT_SPARE     = 2'd3;  // unused code, behaves as first fit
    localparam int unsigned    SETTLE_CYCLES = 24;
    localparam int unsigned    CYCLE_LIMIT   = 400000;
    localparam int unsigned    RAND_PHASES   = 30;
    localparam int unsigned    PHASE_WORDS   = 40;
    localparam int unsigned    MAX_REPORTS   = 10;

    logic                            i_clk;
    logic                            i_rst_n    = 1'b0;
    logic                            start      = 1'b0;
    logic                            busy;
    fpba_pkg::t_in_word              i_in_word  = '0;
    logic                            o_result_strobe;
    fpba_pkg::t_out_word             o_out_word;
    logic                            i_cfg_we   = 1'b0;
    logic [fpba_pkg::CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [fpba_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    // Shadow copy of the free-space table and the two registers.
    logic [fpba_pkg::AMT_FIELD_W-1:0] free_sz [BLOCKS];
    logic [1:0]                       mode_m;
    logic [4:0]                       count_m;

    fpba_pkg::t_in_word  word_q [$];
    fpba_pkg::t_out_word grant_q [$];
    fpba_pkg::t_out_word want_r;

    int unsigned idle_pct    = 13;
    int unsigned words_sent  = 0;
    int unsigned results_got = 0;
    int unsigned grants_got  = 0;
    int unsigned cfg_writes  = 0;
    int unsigned mism        = 0;
    int unsigned cyc         = 0;

    fit_policy_block_allocator u_top (
        .i_clk,
        .i_rst_n,
        .start,
        .busy,
        .i_in_word,
        .o_result_strobe,
        .o_out_word,
        .i_cfg_we,
        .i_cfg_idx,
        .i_cfg_data
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Search the shadow table under the current policy and take the amount
    // from the chosen block.
    function automatic fpba_pkg::t_out_word allocate(
        input logic [fpba_pkg::AMT_FIELD_W-1:0] amt);
        int unsigned         lim;
        int unsigned         pick;
        bit                  found;
        fpba_pkg::t_out_word r;
        lim   = (count_m > BLOCKS) ? BLOCKS : count_m;
        pick  = 0;
        found = 1'b0;
        r     = '0;
        for (int unsigned j = 0; j < lim; j++) begin
            if (amt > free_sz[j]) continue;
            if (!found) begin
                found = 1'b1;
                pick  = j;
                if (mode_m != fpba_pkg::FIT_BEST && mode_m != fpba_pkg::FIT_WORST) break;
            end else if (mode_m == fpba_pkg::FIT_BEST && free_sz[j] < free_sz[pick]) begin
                pick = j;
            end else if (mode_m == fpba_pkg::FIT_WORST && free_sz[j] > free_sz[pick]) begin
                pick = j;
            end
        end
        if (found) begin
            free_sz[pick]  = free_sz[pick] - amt;
            r.granted      = 1'b1;
            r.chosen_block = pick[fpba_pkg::IDX_FIELD_W-1:0];
            r.space_left   = free_sz[pick];
        end
        return r;
    endfunction

    task automatic push_word(input logic op, input logic [fpba_pkg::IDX_FIELD_W-1:0] idx,
                             input logic [fpba_pkg::AMT_FIELD_W-1:0] amt);
        fpba_pkg::t_in_word w;
        w.op         = op;
        w.load_index = idx;
        w.amount     = amt;
        word_q.push_back(w);
    endtask

    task automatic cfg_write(input logic [fpba_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fpba_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == fpba_pkg::REG_FIT_MODE) begin
            mode_m = data[1:0];
        end else begin
            count_m = data;
        end
        cfg_writes++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every word is taken and every result is back, then let the
    // bench idle before anything else happens.
    task automatic drain();
        while (word_q.size() != 0 || start || grant_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Driver: a word is taken when start is high and busy is low.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && busy)) begin
            if (start) begin
                words_sent++;
                if (i_in_word.op == fpba_pkg::OP_LOAD) begin
                    free_sz[i_in_word.load_index] = i_in_word.amount;
                end else begin
                    grant_q.push_back(allocate(i_in_word.amount));
                end
            end
            if (word_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                i_in_word <= word_q.pop_front();
                start     <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: each strobed result is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe) begin
            results_got++;
            if (o_out_word.granted === 1'b1) grants_got++;
            if (grant_q.size() == 0) begin
                mism++;
                if (mism <= MAX_REPORTS)
                    $display("unexpected result: granted %b block %0d left %0d",
                             o_out_word.granted, o_out_word.chosen_block,
                             o_out_word.space_left);
            end else begin
                want_r = grant_q.pop_front();
                if (o_out_word.granted !== want_r.granted ||
                    o_out_word.chosen_block !== want_r.chosen_block ||
                    o_out_word.space_left !== want_r.space_left) begin
                    mism++;
                    if (mism <= MAX_REPORTS)
                        $display("mismatch: expected %b/%0d/%0d got %b/%0d/%0d",
                                 want_r.granted, want_r.chosen_block, want_r.space_left,
                                 o_out_word.granted, o_out_word.chosen_block,
                                 o_out_word.space_left);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        logic [fpba_pkg::AMT_FIELD_W-1:0] seed_sizes [BLOCKS];
        logic [fpba_pkg::AMT_FIELD_W-1:0] amt;
        logic [fpba_pkg::AMT_FIELD_W-1:0] last_load;
        logic [fpba_pkg::CFG_DATA_W-1:0]  data;
        seed_sizes = '{16'd100, 16'd0, 16'hFFFF, 16'd500, 16'd100, 16'hFFFF, 16'd1,
                       16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA, 16'd200, 16'd300,
                       16'd50, 16'h0F0F, 16'hF0F0};
        mode_m    = fpba_pkg::FIT_MODE_RST;
        count_m   = fpba_pkg::BLOCK_COUNT_RST;
        last_load = 16'd100;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill every block, with ties and both extremes, then probe first fit:
        // a zero request, two full-size requests and one that fits nowhere.
        for (int unsigned k = 0; k < BLOCKS; k++)
            push_word(fpba_pkg::OP_LOAD, k[fpba_pkg::IDX_FIELD_W-1:0], seed_sizes[k]);
        push_word(fpba_pkg::OP_REQUEST, 4'($urandom), 16'd0);
        push_word(fpba_pkg::OP_REQUEST, 4'($urandom), 16'hFFFF);
        push_word(fpba_pkg::OP_REQUEST, 4'($urandom), 16'hFFFF);
        push_word(fpba_pkg::OP_REQUEST, 4'($urandom), 16'hFFFF);
        drain();

        // Best fit with a tie between two equal blocks.
        cfg_write(fpba_pkg::REG_FIT_MODE, {3'b000, fpba_pkg::FIT_BEST});
        push_word(fpba_pkg::OP_REQUEST, 4'($urandom), 16'd100);
        push_word(fpba_pkg::OP_REQUEST, 4'($urandom), 16'd1);
        drain();

        // Worst fit, written with junk in the upper data bits.
        cfg_write(fpba_pkg::REG_FIT_MODE, {3'b111, fpba_pkg::FIT_WORST});
        push_word(fpba_pkg::OP_REQUEST, 4'($urandom), 16'd1);
        drain();

        cfg_write(fpba_pkg::REG_FIT_MODE, {3'b000, FIT_SPARE});
        push_word(fpba_pkg::OP_REQUEST, 4'($urandom), 16'd1);
        drain();

        // No block in use, an oversized count, and a single block.
        cfg_write(fpba_pkg::REG_BLOCK_COUNT, 5'd0);
        push_word(fpba_pkg::OP_REQUEST, 4'($urandom), 16'd0);
        drain();
        cfg_write(fpba_pkg::REG_BLOCK_COUNT, 5'd31);
        push_word(fpba_pkg::OP_REQUEST, 4'($urandom), 16'd0);
        drain();
        cfg_write(fpba_pkg::REG_BLOCK_COUNT, 5'd1);
        push_word(fpba_pkg::OP_REQUEST, 4'($urandom), 16'd1);
        drain();

        // Random phases, each under a fresh policy and block count.
        for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
            idle_pct = (ph < RAND_PHASES / 3) ? 13 : (ph < 2 * RAND_PHASES / 3) ? 48 : 0;
            data = 5'($urandom);
            if ($urandom_range(0, 3) != 0) data[4:2] = 3'b000;
            cfg_write(fpba_pkg::REG_FIT_MODE, data);
            case ($urandom_range(0, 9))
                0:       data = 5'd0;
                1:       data = 5'd1;
                2:       data = 5'd16;
                3:       data = 5'd31;
                4:       data = 5'($urandom_range(17, 31));
                default: data = 5'($urandom_range(2, 16));
            endcase
            cfg_write(fpba_pkg::REG_BLOCK_COUNT, data);

            for (int unsigned k = 0; k < PHASE_WORDS; k++) begin
                if ($urandom_range(0, 99) < 35) begin
                    case ($urandom_range(0, 7))
                        0:       amt = 16'd0;
                        1:       amt = 16'hFFFF;
                        2:       amt = last_load;
                        3:       amt = 16'($urandom_range(0, 255));
                        default: amt = 16'($urandom);
                    endcase
                    last_load = amt;
                    push_word(fpba_pkg::OP_LOAD, 4'($urandom), amt);
                end else begin
                    case ($urandom_range(0, 9))
                        0:       amt = 16'd0;
                        1:       amt = 16'hFFFF;
                        2:       amt = 16'($urandom);
                        3:       amt = 16'($urandom_range(0, 255));
                        default: amt = 16'($urandom_range(0, 4095));
                    endcase
                    push_word(fpba_pkg::OP_REQUEST, 4'($urandom), amt);
                end
            end
            drain();
        end

        $display("summary: %0d words taken over %0d register writes", words_sent, cfg_writes);
        $display("summary: %0d results checked, %0d granted, %0d mismatches",
                 results_got, grants_got, mism);
        if (mism == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/fpba_pkg.sv
rtl/core/fpba_ctrl.sv
rtl/core/fpba_dp.sv
rtl/core/fit_policy_block_allocator.sv
tb/tb.sv
